// ===== rtl/core/nvg_pkg.sv =====
package nvg_pkg;

	localparam int COUNT_W = 21;
	localparam int CLOCK_W = 63;
	localparam int RATE_W  = 51;
	localparam int TOT_W   = 52;
	localparam int REM_W   = 53;
	localparam int ITER_W  = 7;

	localparam logic [COUNT_W-1:0] AGENTS_RST = 21'd10000;
	localparam logic [COUNT_W-1:0] START_RST  = 21'd5000;
	localparam logic [15:0]        NOISE_RST  = 16'd512;
	localparam logic [2:0]         ETA_RST    = 3'd0;
	localparam logic [2:0]         ETA_NONE   = 3'd3;
	localparam logic [CLOCK_W-1:0] CLOCK_MAX  = {CLOCK_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

	typedef enum logic [2:0] {
		REG_AGENTS = 3'd0,
		REG_START  = 3'd1,
		REG_BNOISE = 3'd2,
		REG_DNOISE = 3'd3,
		REG_ETA    = 3'd4
	} nvg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MB, ST_MD, ST_MP, ST_TS, ST_ML, ST_MH, ST_BR,
		ST_RHO, ST_SQ, ST_POW, ST_POWW, ST_EM, ST_EMW, ST_DT,
		ST_UPD, ST_RC, ST_RN, ST_FIN
	} nvg_state_t;

	typedef struct packed {
		logic              start;
		logic              sqrt_mode;
		logic [ITER_W-1:0] iters;
		logic [REM_W-1:0]  r_init;
		logic [63:0]       n_init;
		logic [REM_W-1:0]  den;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/core/nvg_in_if.sv =====
interface nvg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] exp_draw;
	logic [31:0] uniform_draw;

	modport source (output valid, exp_draw, uniform_draw, input ready);
	modport sink (input valid, exp_draw, uniform_draw, output ready);
endinterface

// ===== rtl/core/nvg_out_if.sv =====
interface nvg_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] prior_scaled_count;
	logic [62:0] new_clock;
	logic        was_birth;
	logic        did_rescale;

	modport source (output valid, prior_scaled_count, new_clock, was_birth, did_rescale,
		input ready);
	modport sink (input valid, prior_scaled_count, new_clock, was_birth, did_rescale,
		output ready);
endinterface

// ===== rtl/core/nvg_mul.sv =====
module nvg_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	output logic [63:0] p
);
	// registered multiply with a small addend
	always_ff @(posedge clk) begin
		p <= a * b + {32'b0, c};
	end
endmodule

// ===== rtl/core/nvg_divsqrt.sv =====
module nvg_divsqrt import nvg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_cmd_t    cmd,
	output div_stat_t   stat,
	output logic [63:0] quo
);
	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic              sqrt_q;
	logic [REM_W-1:0]  r_q;
	logic [63:0]       n_q;
	logic [REM_W-1:0]  d_q;
	logic [63:0]       q_q;
	logic [REM_W-1:0]  rsh;
	logic [REM_W-1:0]  sub;
	logic              ge;

	// one quotient or root bit a step
	always_comb begin
		if (sqrt_q) begin
			rsh = {r_q[REM_W-3:0], n_q[63:62]};
			sub = {q_q[REM_W-3:0], 2'b01};
		end else begin
			rsh = {r_q[REM_W-2:0], n_q[63]};
			sub = d_q;
		end
		ge = (rsh >= sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == ITER_W'(1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.sqrt_mode;
			r_q    <= cmd.r_init;
			n_q    <= cmd.n_init;
			d_q    <= cmd.den;
			q_q    <= '0;
		end else if (busy_q) begin
			r_q <= ge ? rsh - sub : rsh;
			n_q <= sqrt_q ? {n_q[61:0], 2'b00} : {n_q[62:0], 1'b0};
			q_q <= {q_q[62:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = q_q;
endmodule

// ===== rtl/core/noisy_voter_gillespie_step.sv =====
// channel   dir  handshake         payload
// in_ch     in   valid / ready     exp_draw, uniform_draw
// out_ch    out  valid / ready     prior_scaled_count, new_clock, was_birth, did_rescale
// apb       in   psel / penable    five registers at byte address 4*i
//
// one event runs from one accepted transaction to the next through the rates and the birth
// test, the ratio, the square root when the exponent is odd, the power, the draw multiply,
// the time step and the update, and a zero total rate skips straight to the update;
// a rescale adds reciprocal multiplies that divide the count and the agents by the factor
// in_ch.ready is high only while the sequencer is idle; a finished result waits in the
// output register and the next transaction can be taken meanwhile
// reset and any register write restart the population, scale and clock
module noisy_voter_gillespie_step import nvg_pkg::*; #(
	parameter int SWITCH_LEVEL       = 100,
	parameter int RESCALE_FACTOR     = 10,
	parameter int RESCALE_MIN_AGENTS = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	nvg_in_if.sink      in_ch,
	nvg_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	// reciprocal of the rescale factor, exact for every count value
	localparam int          RC_SHIFT = COUNT_W + $clog2(RESCALE_FACTOR);
	localparam logic [63:0] RC_RECIP = ((64'd1 << RC_SHIFT) + 64'(RESCALE_FACTOR) - 64'd1) /
		64'(RESCALE_FACTOR);

	// configuration registers
	logic [COUNT_W-1:0] agent_q, start_q;
	logic [15:0]        bnoise_q, dnoise_q;
	logic [2:0]         eta_q;

	// model state
	nvg_state_t         state_q, state_d;
	logic [COUNT_W-1:0] count_q, n_q, scale_q;
	logic [CLOCK_W-1:0] clock_q;
	logic               out_valid_q;

	// per-event working registers
	logic [31:0]        ed_q, ud_q;
	logic [COUNT_W-1:0] nmx_q, prior_q;
	logic [RATE_W-1:0]  b_q, d_q;
	logic [TOT_W-1:0]   t_q;
	logic               birth_q, resc_q;
	logic [31:0]        rho_q, s_q, q_q;
	logic               q_one_q, odd_q;
	logic [1:0]         pw_q;
	logic [47:0]        dt_q;
	logic [COUNT_W-1:0] o_prior_q;
	logic [CLOCK_W-1:0] o_clock_q;
	logic               o_birth_q, o_resc_q;

	// shared units
	logic [31:0] mul_a, mul_b, mul_c;
	logic [63:0] mul_p;
	div_cmd_t    dcmd;
	div_stat_t   dstat;
	logic [63:0] quo;

	nvg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .c(mul_c), .p(mul_p));
	nvg_divsqrt u_div (.clk(clk), .arst_n(arst_n), .cmd(dcmd), .stat(dstat), .quo(quo));

	// configuration port
	logic     wr_en, restart;
	nvg_reg_t widx;
	assign widx    = nvg_reg_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite;
	assign restart = wr_en && (paddr[4:2] <= 3'(REG_ETA));
	assign pready  = 1'b1;

	always_comb begin
		unique case (widx)
			REG_AGENTS: prdata = {11'b0, agent_q};
			REG_START:  prdata = {11'b0, start_q};
			REG_BNOISE: prdata = {16'b0, bnoise_q};
			REG_DNOISE: prdata = {16'b0, dnoise_q};
			REG_ETA:    prdata = {29'b0, eta_q};
			default:    prdata = '0;
		endcase
	end

	// exponent k of the ratio, in half powers
	logic [2:0] k_w;
	assign k_w = (eta_q == ETA_NONE) ? 3'd0 : 3'd2 - eta_q;

	// clamped ratio numerator in half agents
	logic [COUNT_W:0] c2_w;
	always_comb begin
		if (count_q == '0) begin
			c2_w = (COUNT_W+1)'(1);
		end else if (count_q >= n_q) begin
			c2_w = {n_q, 1'b0} - (COUNT_W+1)'(1);
		end else begin
			c2_w = {count_q, 1'b0};
		end
	end

	// event outcome
	logic [COUNT_W-1:0]        new_x;
	logic signed [COUNT_W+1:0] lx_s, nx_s, alt_s;
	logic                      resc_w;
	logic [63:0]               clk_sum;
	logic [31:0]               scale_prod;
	assign new_x   = birth_q ? count_q + COUNT_W'(1) : count_q - COUNT_W'(1);
	assign lx_s    = signed'({2'b00, count_q});
	assign nx_s    = signed'({2'b00, new_x});
	assign alt_s   = signed'({2'b00, n_q}) - (COUNT_W+2)'(SWITCH_LEVEL);
	assign resc_w  = ({1'b0, n_q} > (COUNT_W+1)'(RESCALE_MIN_AGENTS)) &&
		(((lx_s < (COUNT_W+2)'(SWITCH_LEVEL)) && (nx_s == (COUNT_W+2)'(SWITCH_LEVEL))) ||
		((lx_s > alt_s) && (nx_s == alt_s)));
	assign clk_sum    = {1'b0, clock_q} + {16'b0, dt_q};
	assign scale_prod = {11'b0, scale_q} * 32'(RESCALE_FACTOR);

	// sequencer: next state, multiplier operands and divider commands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		mul_c   = '0;
		dcmd    = '0;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid) begin
				state_d = ST_MB;
			end
			ST_MB: begin
				mul_a   = {11'b0, nmx_q};
				mul_b   = {2'b0, 30'(bnoise_q) + {1'b0, count_q, 8'b0}};
				state_d = ST_MD;
			end
			ST_MD: begin
				mul_a   = {11'b0, count_q};
				mul_b   = {2'b0, 30'(dnoise_q) + {1'b0, nmx_q, 8'b0}};
				state_d = ST_MP;
			end
			ST_MP: begin
				mul_a   = {11'b0, count_q};
				mul_b   = {11'b0, scale_q};
				state_d = ST_TS;
			end
			ST_TS: state_d = ST_ML;
			ST_ML: begin
				mul_a   = ud_q;
				mul_b   = t_q[31:0];
				state_d = (t_q == '0) ? ST_UPD : ST_MH;
			end
			ST_MH: begin
				mul_a   = ud_q;
				mul_b   = {12'b0, t_q[TOT_W-1:32]};
				mul_c   = mul_p[63:32];
				state_d = ST_BR;
			end
			ST_BR: begin
				if ((n_q == '0) || (k_w == 3'd0)) begin
					state_d = ST_EM;
				end else begin
					dcmd.start  = 1'b1;
					dcmd.iters  = ITER_W'(32);
					dcmd.r_init = REM_W'(c2_w);
					dcmd.den    = REM_W'({n_q, 1'b0});
					state_d     = ST_RHO;
				end
			end
			ST_RHO: if (dstat.done) begin
				if (odd_q) begin
					dcmd.start     = 1'b1;
					dcmd.sqrt_mode = 1'b1;
					dcmd.iters     = ITER_W'(32);
					dcmd.n_init    = {quo[31:0], 32'b0};
					state_d        = ST_SQ;
				end else begin
					state_d = ST_POW;
				end
			end
			ST_SQ: if (dstat.done) begin
				state_d = ST_POW;
			end
			ST_POW: begin
				if ((pw_q != 2'd0) || odd_q) begin
					if (!q_one_q) begin
						mul_a   = q_q;
						mul_b   = (pw_q != 2'd0) ? rho_q : s_q;
						state_d = ST_POWW;
					end
				end else begin
					state_d = ST_EM;
				end
			end
			ST_POWW: state_d = ST_POW;
			ST_EM: begin
				if (q_one_q) begin
					dcmd.start  = 1'b1;
					dcmd.iters  = ITER_W'(64);
					dcmd.n_init = {ed_q, 32'b0};
					dcmd.den    = REM_W'(t_q);
					state_d     = ST_DT;
				end else begin
					mul_a   = ed_q;
					mul_b   = q_q;
					state_d = ST_EMW;
				end
			end
			ST_EMW: begin
				dcmd.start  = 1'b1;
				dcmd.iters  = ITER_W'(64);
				dcmd.n_init = mul_p;
				dcmd.den    = REM_W'(t_q);
				state_d     = ST_DT;
			end
			ST_DT: if (dstat.done) begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if ((t_q != '0) && resc_w) begin
					// count divided by the factor through its reciprocal
					mul_a   = {11'b0, new_x};
					mul_b   = RC_RECIP[31:0];
					state_d = ST_RC;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_RC: begin
				mul_a   = {11'b0, n_q};
				mul_b   = RC_RECIP[31:0];
				state_d = ST_RN;
			end
			ST_RN: state_d = ST_FIN;
			ST_FIN: if (!out_valid_q || out_ch.ready) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agent_q     <= AGENTS_RST;
			start_q     <= START_RST;
			bnoise_q    <= NOISE_RST;
			dnoise_q    <= NOISE_RST;
			eta_q       <= ETA_RST;
			count_q     <= START_RST;
			n_q         <= AGENTS_RST;
			scale_q     <= COUNT_W'(1);
			clock_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (restart) begin
				unique case (widx)
					REG_AGENTS: agent_q <= pwdata[COUNT_W-1:0];
					REG_START:  start_q <= pwdata[COUNT_W-1:0];
					REG_BNOISE: bnoise_q <= pwdata[15:0];
					REG_DNOISE: dnoise_q <= pwdata[15:0];
					REG_ETA:    eta_q <= pwdata[2:0];
					default:    agent_q <= agent_q;
				endcase
				count_q <= (widx == REG_START) ? pwdata[COUNT_W-1:0] : start_q;
				n_q     <= (widx == REG_AGENTS) ? pwdata[COUNT_W-1:0] : agent_q;
				scale_q <= COUNT_W'(1);
				clock_q <= '0;
			end
			// a new result replaces one that leaves in the same cycle
			if ((state_q == ST_FIN) && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_UPD: begin
					if (t_q == '0) begin
						clock_q <= CLOCK_MAX;
					end else begin
						clock_q <= clk_sum[63] ? CLOCK_MAX : clk_sum[CLOCK_W-1:0];
						count_q <= new_x;
						if (resc_w) begin
							scale_q <= (scale_prod > 32'(COUNT_MAX)) ? COUNT_MAX :
								scale_prod[COUNT_W-1:0];
						end
					end
				end
				ST_RC: count_q <= mul_p[RC_SHIFT +: COUNT_W];
				ST_RN: n_q <= mul_p[RC_SHIFT +: COUNT_W];
				default: ;
			endcase
		end
	end

	// per-event datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ed_q  <= in_ch.exp_draw;
				ud_q  <= in_ch.uniform_draw;
				nmx_q <= (n_q > count_q) ? n_q - count_q : '0;
			end
			ST_MD: b_q <= mul_p[RATE_W-1:0];
			ST_MP: d_q <= mul_p[RATE_W-1:0];
			ST_TS: begin
				t_q     <= {1'b0, b_q} + {1'b0, d_q};
				prior_q <= (mul_p[63:COUNT_W] != '0) ? COUNT_MAX : mul_p[COUNT_W-1:0];
			end
			ST_BR: begin
				// birth iff uniform * total < birth rate * 2^32
				birth_q <= (mul_p < {13'b0, b_q});
				q_one_q <= 1'b1;
				pw_q    <= (n_q == '0) ? 2'd0 : k_w[2:1];
				odd_q   <= (n_q == '0) ? 1'b0 : k_w[0];
			end
			ST_RHO: if (dstat.done) begin
				rho_q <= quo[31:0];
			end
			ST_SQ: if (dstat.done) begin
				s_q <= quo[31:0];
			end
			ST_POW: begin
				// first factor against one needs no multiply
				if (q_one_q && (pw_q != 2'd0)) begin
					q_q     <= rho_q;
					q_one_q <= 1'b0;
					pw_q    <= pw_q - 2'd1;
				end else if (q_one_q && odd_q) begin
					q_q     <= s_q;
					q_one_q <= 1'b0;
					odd_q   <= 1'b0;
				end
			end
			ST_POWW: begin
				q_q <= mul_p[63:32];
				if (pw_q != 2'd0) begin
					pw_q <= pw_q - 2'd1;
				end else begin
					odd_q <= 1'b0;
				end
			end
			ST_DT: if (dstat.done) begin
				dt_q <= quo[63:16];
			end
			ST_UPD: begin
				resc_q <= (t_q != '0) && resc_w;
				if (t_q == '0) begin
					birth_q <= 1'b0;
				end
			end
			ST_FIN: if (!out_valid_q || out_ch.ready) begin
				o_prior_q <= prior_q;
				o_clock_q <= clock_q;
				o_birth_q <= birth_q;
				o_resc_q  <= resc_q;
			end
			default: ;
		endcase
	end

	assign in_ch.ready               = (state_q == ST_IDLE);
	assign out_ch.valid              = out_valid_q;
	assign out_ch.prior_scaled_count = o_prior_q;
	assign out_ch.new_clock          = o_clock_q;
	assign out_ch.was_birth          = o_birth_q;
	assign out_ch.did_rescale        = o_resc_q;

`ifndef NO_ASSERTIONS
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> (state_q == ST_RHO || state_q == ST_SQ || state_q == ST_DT))
		else $error("shift-subtract unit busy outside a wait state");
	a_clock_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (clock_q >= $past(clock_q)))
		else $error("simulated clock went backward within an event");
	a_rescale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && t_q != '0 && resc_w) |=>
		(scale_q != $past(scale_q) || scale_q == COUNT_MAX))
		else $error("rescale without a change of scale");
`endif
endmodule

// ===== dv/tb_noisy_voter_gillespie_step.sv =====
`timescale 1ns / 1ps

module tb_noisy_voter_gillespie_step;
	import nvg_pkg::*;

	// one expected event outcome
	typedef struct {
		logic [20:0] prior_scaled_count;
		logic [62:0] new_clock;
		logic        was_birth;
		logic        did_rescale;
	} event_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	nvg_in_if in_ch ();
	nvg_out_if out_ch ();

	noisy_voter_gillespie_step uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// shadow configuration and population state
	logic [20:0] cfg_agents, cfg_start;
	logic [15:0] cfg_bnoise, cfg_dnoise;
	logic signed [2:0] cfg_eta;
	logic [63:0] pop_count, pop_agents, pop_scale, pop_clock;

	event_outcome_t expected_events[$];
	int mismatch_count = 0;
	int events_checked = 0;
	int births_seen = 0;
	int rescales_seen = 0;
	int stall_pct = 30;

	function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] sat_mul64(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		return (p[127:64] != 0) ? '1 : p[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// (x/n)^(k/2) in Q0.32 with x clamped to half an agent at both ends
	function automatic logic [63:0] ratio_power(logic [63:0] n, logic [63:0] x);
		int k;
		logic [63:0] c2, rho, s, q;
		k = (cfg_eta <= 2) ? 2 - cfg_eta : 0;
		q = 64'd1 << 32;
		if (n == 0) return q;
		if (x < 1) c2 = 1;
		else if (x >= n) c2 = 2 * n - 1;
		else c2 = 2 * x;
		rho = (c2 << 32) / (2 * n);
		s = int_sqrt(rho << 32);
		for (int i = 0; i < k / 2; i++) q = (q * rho) >> 32;
		if (k % 2 != 0) q = (q * s) >> 32;
		return q;
	endfunction

	function automatic void restart_population();
		pop_count = cfg_start;
		pop_agents = cfg_agents;
		pop_scale = 1;
		pop_clock = 0;
	endfunction

	// one Gillespie event against the shadow state
	function automatic event_outcome_t predict_event(logic [31:0] ed, logic [31:0] ud);
		event_outcome_t o;
		logic [63:0] n, x, nmx, b, d, t, prior, q, dt;
		logic [127:0] lhs, num;
		logic signed [63:0] alt;
		logic brth, resc;
		n = pop_agents;
		x = pop_count;
		nmx = (n > x) ? n - x : 0;
		b = sat_mul64(nmx, cfg_bnoise + (x << 8));
		d = sat_mul64(x, sat_add64(cfg_dnoise, sat_mul64(nmx, 256)));
		t = sat_add64(b, d);
		prior = sat_mul64(x, pop_scale);
		if (prior > COUNT_MAX) prior = COUNT_MAX;
		brth = 0;
		resc = 0;
		if (t == 0) begin
			pop_clock = {1'b0, CLOCK_MAX};
		end else begin
			lhs = ud * t;
			brth = (lhs[127:32] < {32'd0, b});
			pop_count = brth ? x + 1 : x - 1;
			q = ratio_power(n, x);
			num = ed * q;
			dt = (num / t) >> 16;
			pop_clock = sat_add64(pop_clock, dt);
			if (pop_clock > {1'b0, CLOCK_MAX}) pop_clock = {1'b0, CLOCK_MAX};
			alt = $signed(n) - 100;
			if (n > 1000 && (($signed(x) < 100 && pop_count == 100) ||
				($signed(x) > alt && $signed(pop_count) == alt))) begin
				resc = 1;
				pop_scale = pop_scale * 10;
				if (pop_scale > COUNT_MAX) pop_scale = COUNT_MAX;
				pop_count = pop_count / 10;
				pop_agents = pop_agents / 10;
			end
		end
		o.prior_scaled_count = prior[20:0];
		o.new_clock = pop_clock[62:0];
		o.was_birth = brth;
		o.did_rescale = resc;
		return o;
	endfunction

	// APB write, setup then access phase
	task automatic write_reg(nvg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_AGENTS: cfg_agents = val[20:0];
			REG_START:  cfg_start = val[20:0];
			REG_BNOISE: cfg_bnoise = val[15:0];
			REG_DNOISE: cfg_dnoise = val[15:0];
			REG_ETA:    cfg_eta = val[2:0];
			default: ;
		endcase
		restart_population();
	endtask

	// hold until every expected transaction has drained, block then idle
	task automatic drain();
		int guard;
		guard = 0;
		while (expected_events.size() != 0 && guard < 2000000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic configure(logic [20:0] n, logic [20:0] x, logic [15:0] bn,
		logic [15:0] dn, logic [2:0] eta);
		drain();
		write_reg(REG_AGENTS, 32'(n));
		write_reg(REG_START, 32'(x));
		write_reg(REG_BNOISE, 32'(bn));
		write_reg(REG_DNOISE, 32'(dn));
		write_reg(REG_ETA, 32'(eta));
	endtask

	// send one input transaction; prediction is made when it is accepted
	task automatic send_draws(logic [31:0] ed, logic [31:0] ud);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.exp_draw <= ed;
		in_ch.uniform_draw <= ud;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_events.push_back(predict_event(ed, ud));
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// random burst traffic with gaps
	task automatic send_random(int cnt, bit small_exp);
		int burst;
		logic [31:0] ed;
		burst = 0;
		for (int i = 0; i < cnt; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
			burst--;
			ed = small_exp ? $urandom_range(0, 32'h0400_0000) : $urandom;
			send_draws(ed, $urandom);
		end
	endtask

	// receiver stall pattern: runs of ready and runs of stall
	initial begin
		int run;
		out_ch.ready = 1'b0;
		forever begin
			run = $urandom_range(1, 40);
			if ($urandom_range(0, 99) < stall_pct) begin
				repeat (run) begin
					@(negedge clk);
					out_ch.ready <= 1'b0;
				end
			end else begin
				repeat (run) begin
					@(negedge clk);
					out_ch.ready <= 1'b1;
				end
			end
		end
	end

	// checker, sampled on the rising edge
	always @(posedge clk) begin
		event_outcome_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_events.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected transaction: count %0d clock %h",
						out_ch.prior_scaled_count, out_ch.new_clock);
			end else begin
				e = expected_events.pop_front();
				events_checked++;
				births_seen += e.was_birth;
				rescales_seen += e.did_rescale;
				if (out_ch.prior_scaled_count !== e.prior_scaled_count ||
					out_ch.new_clock !== e.new_clock ||
					out_ch.was_birth !== e.was_birth ||
					out_ch.did_rescale !== e.did_rescale) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch #%0d: exp cnt %0d clk %h b %0b r %0b",
							events_checked, e.prior_scaled_count, e.new_clock,
							e.was_birth, e.did_rescale);
						$display("    got cnt %0d clk %h b %0b r %0b",
							out_ch.prior_scaled_count, out_ch.new_clock,
							out_ch.was_birth, out_ch.did_rescale);
					end
				end
			end
		end
	end

	// directed: extremes of the draws and of the registers, zero total rate
	task automatic test_directed();
		configure(21'd10000, 21'd5000, 16'd512, 16'd512, 3'd0);
		send_draws(32'h0, 32'h0);
		send_draws(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_draws(32'h0100_0000, 32'h8000_0000);
		send_draws(32'h5555_5555, 32'hAAAA_AAAA);
		// zero total rate: x = 0 with no birth noise
		configure(21'd50, 21'd0, 16'd0, 16'd300, 3'd1);
		send_draws(32'h0100_0000, 32'h1234_5678);
		// zero agents with the no-exponent eta code, then a single agent
		configure(21'd0, 21'd0, 16'hFFFF, 16'hFFFF, ETA_NONE);
		send_draws(32'h0100_0000, 32'h4000_0000);
		send_draws(32'hFFFF_FFFF, 32'h0);
		configure(21'd1, 21'd1, 16'd1, 16'd0, 3'b100);
		send_draws(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_draws(32'h0000_0001, 32'h0000_0001);
		// count equal to agents: only deaths
		configure(21'h1FFFFF, 21'h1FFFFF, 16'hFFFF, 16'hFFFF, 3'd2);
		send_draws(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		configure(21'd10, 21'd200, 16'd0, 16'd0, 3'b111);
		send_draws(32'h0200_0000, 32'hFFFF_FFFF);
		send_draws(32'h0200_0000, 32'h0);
		configure(21'd1048576, 21'd1048576, 16'd0, 16'd1, 3'b110);
		send_draws(32'h8000_0000, 32'h8000_0000);
		send_draws(32'h8000_0000, 32'h1);
	endtask

	// rescale near both thresholds, with strong drift toward them
	task automatic test_rescale();
		configure(21'd5000, 21'd95, 16'hFFFF, 16'd0, 3'b101);
		send_random(40, 1);
		configure(21'd3000, 21'd2905, 16'd0, 16'hFFFF, 3'd2);
		send_random(40, 1);
		// count just below the switch level with a large agent number
		configure(21'd1048576, 21'd99, 16'hFFFF, 16'd0, 3'd1);
		send_random(60, 1);
	endtask

	// broad random run across configurations
	task automatic test_random_configs();
		for (int p = 0; p < 12; p++) begin
			configure(21'($urandom_range(0, 1048576)), 21'($urandom_range(0, 3000)),
				16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)));
			if (p % 3 == 0) stall_pct = 0;
			else stall_pct = $urandom_range(10, 70);
			send_random(55, p[0]);
		end
		stall_pct = 30;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.exp_draw = '0;
		in_ch.uniform_draw = '0;
		cfg_agents = AGENTS_RST;
		cfg_start = START_RST;
		cfg_bnoise = NOISE_RST;
		cfg_dnoise = NOISE_RST;
		cfg_eta = ETA_RST;
		restart_population();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// a few events from the reset configuration
		send_random(8, 0);
		test_directed();
		test_rescale();
		test_random_configs();
		drain();
		$display("checked %0d events: %0d births, %0d rescales", events_checked,
			births_seen, rescales_seen);
		if (mismatch_count == 0 && expected_events.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d failures, %0d outcomes left", mismatch_count,
				expected_events.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
